// File: design/integer_execute_unit_defines.svh
// Assertion macros for the integer execute unit.
`ifndef INTEGER_EXECUTE_UNIT_DEFINES_SVH
`define INTEGER_EXECUTE_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define IEU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define IEU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/ieu_pkg.sv
// Shared types and constants for the integer execute unit.
package ieu_pkg;

  localparam int unsigned XLEN     = 32;
  localparam int unsigned KindW    = 5;
  localparam int unsigned ImmW     = 22;
  localparam int unsigned ShAmtW   = 5;

  localparam logic [XLEN-1:0] CmpLess  = 32'hFFFF_FFFE;
  localparam logic [XLEN-1:0] LinkStep = 32'd4;

  typedef enum logic [KindW-1:0] {
    KAdd  = 5'd0,  KSub  = 5'd1,  KNot  = 5'd2,  KAnd  = 5'd3,  KOr   = 5'd4,
    KXor  = 5'd5,  KShl  = 5'd6,  KSar  = 5'd7,  KShr  = 5'd8,  KCmp  = 5'd9,
    KAddi = 5'd10, KSubi = 5'd11, KNoti = 5'd12, KAndi = 5'd13, KOri  = 5'd14,
    KXori = 5'd15, KShli = 5'd16, KSari = 5'd17, KShri = 5'd18, KCmpi = 5'd19,
    KLi   = 5'd20, KLui  = 5'd21, KLni  = 5'd22, KJ    = 5'd23, KJal  = 5'd24,
    KJr   = 5'd25, KJrl  = 5'd26, KBeq  = 5'd27, KBne  = 5'd28, KBgt  = 5'd29,
    KBlt  = 5'd30
  } kind_e;

  // One instruction word as held in the input register
  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [XLEN-1:0]  operand_a;
    logic [XLEN-1:0]  operand_b;
    logic [ImmW-1:0]  immediate;
    logic [XLEN-1:0]  pc_in;
  } ieu_req_t;

  // One result word
  typedef struct packed {
    logic [XLEN-1:0] result;
    logic [XLEN-1:0] next_pc;
    logic            taken;
  } ieu_rsp_t;

endpackage

// File: design/ieu_alu.sv
// Combinational datapath: ALU, immediate loads, jump and branch targets.
module ieu_alu (
  input  ieu_pkg::ieu_req_t req_i,
  output ieu_pkg::ieu_rsp_t rsp_o
);
  import ieu_pkg::*;

  logic [XLEN-1:0] a, b, pc, src2, i12, i16;
  logic [XLEN-1:0] sext21, sext14, imm22, link;
  logic [XLEN-1:0] addsub, shl, shr, sar;
  logic [XLEN-1:0] cmp_res, jr_tgt, jmp_rel;
  logic            imm_form, is_sub, sh_big, sar_fill, cond;
  logic [ShAmtW-1:0] sh_amt;
  kind_e           kind;

  assign kind   = kind_e'(req_i.kind);
  assign a      = req_i.operand_a;
  assign b      = req_i.operand_b;
  assign pc     = req_i.pc_in;
  assign i12    = {20'd0, req_i.immediate[11:0]};
  assign i16    = {16'd0, req_i.immediate[15:0]};
  assign imm22  = {10'd0, req_i.immediate};
  assign sext21 = {{11{req_i.immediate[20]}}, req_i.immediate[20:0]};
  assign sext14 = {{18{req_i.immediate[13]}}, req_i.immediate[13:0]};
  assign link   = pc + LinkStep;

  // Second ALU source: register, 12-bit immediate, or 16-bit for cmpi
  assign imm_form = (req_i.kind >= KAddi) && (req_i.kind <= KShri);
  always_comb begin
    if (kind == KCmpi) begin
      src2 = i16;
    end else if (imm_form) begin
      src2 = i12;
    end else begin
      src2 = b;
    end
  end

  // Shared adder for add/sub
  assign is_sub = (kind == KSub) || (kind == KSubi);
  assign addsub = a + (is_sub ? ~src2 : src2) + {31'd0, is_sub};

  // Shifts; amounts of 32 or more saturate
  assign sh_big   = |src2[XLEN-1:ShAmtW];
  assign sh_amt   = src2[ShAmtW-1:0];
  assign sar_fill = a[XLEN-1];
  assign shl      = sh_big ? '0 : (a << sh_amt);
  assign shr      = sh_big ? '0 : (a >> sh_amt);
  assign sar      = sh_big ? {XLEN{sar_fill}} : XLEN'($signed(a) >>> sh_amt);

  // Three-way unsigned compare
  always_comb begin
    if (a > src2) begin
      cmp_res = 32'd1;
    end else if (a < src2) begin
      cmp_res = CmpLess;
    end else begin
      cmp_res = '0;
    end
  end

  // Jump targets
  assign jmp_rel = pc + sext21;
  assign jr_tgt  = pc + a + imm22;

  // Branch condition
  always_comb begin
    case (kind)
      KBeq:    cond = (a == b);
      KBne:    cond = (a != b);
      KBgt:    cond = ($signed(a) > $signed(b));
      KBlt:    cond = ($signed(a) < $signed(b));
      default: cond = 1'b0;
    endcase
  end

  // Result selection
  always_comb begin
    rsp_o.result  = '0;
    rsp_o.next_pc = pc;
    rsp_o.taken   = 1'b0;
    case (kind)
      KAdd, KSub, KAddi, KSubi: rsp_o.result = addsub;
      KNot:  rsp_o.result = (|b) ? (~a + 32'd1) : ~a;
      KNoti: rsp_o.result = ~i12;
      KAnd, KAndi: rsp_o.result = a & src2;
      KOr, KOri:   rsp_o.result = a | src2;
      KXor, KXori: rsp_o.result = a ^ src2;
      KShl, KShli: rsp_o.result = shl;
      KSar, KSari: rsp_o.result = sar;
      KShr, KShri: rsp_o.result = shr;
      KCmp, KCmpi: rsp_o.result = cmp_res;
      KLi:   rsp_o.result = {{16{i16[15]}}, i16[15:0]};
      KLui:  rsp_o.result = {i16[15:0], 16'd0};
      KLni:  rsp_o.result = i16;
      KJ:    rsp_o.next_pc = jmp_rel;
      KJal: begin
        rsp_o.result  = link;
        rsp_o.next_pc = sext21;
      end
      KJr:   rsp_o.next_pc = (a == '0) ? jmp_rel : jr_tgt;
      KJrl: begin
        rsp_o.result  = link;
        rsp_o.next_pc = (a == '0) ? sext21 : jr_tgt;
      end
      KBeq, KBne, KBgt, KBlt: begin
        rsp_o.taken   = cond;
        rsp_o.next_pc = pc + (cond ? sext14 : LinkStep);
      end
      default: ;
    endcase
  end

endmodule

// File: design/integer_execute_unit.sv
// Top level of the integer execute unit: input register, datapath, result register.
//
// Execute stage for a 32-bit core. One instruction word is accepted per clock while
// stall_o is low. The accepting edge loads the input register, the datapath (adder,
// shifter, comparators, target adders) works on the registered word, and the result
// register loads its result word for the outputs. A stall on the output holds the
// result register; the input register keeps taking words until it is also full,
// so stall_o only rises when both stages hold data and stall_i is high. No
// reset-time setup is needed.
module integer_execute_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       stall_o,
  input  logic [ieu_pkg::KindW-1:0]  kind_i,
  input  logic [ieu_pkg::XLEN-1:0]   operand_a_i,
  input  logic [ieu_pkg::XLEN-1:0]   operand_b_i,
  input  logic [ieu_pkg::ImmW-1:0]   immediate_i,
  input  logic [ieu_pkg::XLEN-1:0]   pc_in_i,
  output logic                       valid_o,
  input  logic                       stall_i,
  output logic [ieu_pkg::XLEN-1:0]   result_o,
  output logic [ieu_pkg::XLEN-1:0]   next_pc_o,
  output logic                       taken_o
);
  import ieu_pkg::*;
  `include "integer_execute_unit_defines.svh"

  ieu_req_t req_q, req_d;
  ieu_rsp_t rsp_q, rsp_comb;
  logic     in_valid_q, in_valid_d;
  logic     out_valid_q, out_valid_d;
  logic     in_accept, out_load;

  // Handshake control
  assign out_load  = in_valid_q && (!out_valid_q || !stall_i);
  assign stall_o   = in_valid_q && out_valid_q && stall_i;
  assign in_accept = valid_i && !stall_o;

  assign in_valid_d  = in_accept ? 1'b1 : (out_load ? 1'b0 : in_valid_q);
  assign out_valid_d = out_load ? 1'b1 : (stall_i ? out_valid_q : 1'b0);

  assign req_d = '{kind: kind_i, operand_a: operand_a_i, operand_b: operand_b_i,
                   immediate: immediate_i, pc_in: pc_in_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input register
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q <= req_d;
    end
  end

  ieu_alu u_alu (
    .req_i (req_q),
    .rsp_o (rsp_comb)
  );

  // Result register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      rsp_q <= rsp_comb;
    end
  end

  assign valid_o   = out_valid_q;
  assign result_o  = rsp_q.result;
  assign next_pc_o = rsp_q.next_pc;
  assign taken_o   = rsp_q.taken;

  // Checks
  `IEU_ASSERT_NOW(a_stall_only_full, stall_o, in_valid_q && out_valid_q, "stall_o while not full")
  `IEU_ASSERT_NEXT(a_accept_fills, in_accept, in_valid_q, "accepted word not held")
  `IEU_ASSERT_NEXT(a_load_fills_out, out_load, out_valid_q, "result register not loaded")
  `IEU_ASSERT_NEXT(a_out_hold, out_valid_q && stall_i, out_valid_q && $stable(rsp_q), "stalled result changed")

endmodule

// File: tb/tb_integer_execute_unit.sv
// Self-checking testbench for the integer execute unit: directed and random instruction words.
`timescale 1ns / 1ps

module tb_integer_execute_unit;
  import ieu_pkg::*;

  // Kind code with no operation behind it
  localparam logic [KindW-1:0] KindReserved = 5'd31;
  localparam int unsigned RandPerPhase = 170;
  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned DrainCycles  = 10;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            valid_i = 1'b0;
  logic            stall_o;
  logic [KindW-1:0] kind_i = '0;
  logic [XLEN-1:0] operand_a_i = '0;
  logic [XLEN-1:0] operand_b_i = '0;
  logic [ImmW-1:0] immediate_i = '0;
  logic [XLEN-1:0] pc_in_i = '0;
  logic            valid_o;
  logic            stall_i = 1'b0;
  logic [XLEN-1:0] result_o;
  logic [XLEN-1:0] next_pc_o;
  logic            taken_o;

  ieu_req_t    pending_instrs[$];
  ieu_rsp_t    expected_results[$];
  int          pacing_phase = 0;
  int unsigned err_count = 0;
  int unsigned checked_count = 0;
  int unsigned cycle_count = 0;
  logic [31:0] kinds_seen = '0;

  integer_execute_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (valid_i),
    .stall_o     (stall_o),
    .kind_i      (kind_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .immediate_i (immediate_i),
    .pc_in_i     (pc_in_i),
    .valid_o     (valid_o),
    .stall_i     (stall_i),
    .result_o    (result_o),
    .next_pc_o   (next_pc_o),
    .taken_o     (taken_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Unsigned three-way compare: 1 above, CmpLess below, 0 equal
  function automatic logic [XLEN-1:0] compare3(input logic [XLEN-1:0] a,
                                               input logic [XLEN-1:0] other);
    if (a > other) return 32'd1;
    if (a < other) return CmpLess;
    return '0;
  endfunction

  // True arithmetic right shift, sign fill for amounts of 32 and up
  function automatic logic [XLEN-1:0] shift_arith(input logic [XLEN-1:0] a,
                                                  input logic [XLEN-1:0] amt);
    logic signed [XLEN-1:0] sa;
    sa = $signed(a);
    if (amt >= 32) return {XLEN{a[XLEN-1]}};
    sa = sa >>> amt[4:0];
    return sa;
  endfunction

  // Expected result word for one instruction word
  function automatic ieu_rsp_t execute_instr(input ieu_req_t w);
    logic [XLEN-1:0] a, b, pc, res, npc, i12, i16, jmp_off, br_off;
    logic            cond;
    ieu_rsp_t        r;
    a       = w.operand_a;
    b       = w.operand_b;
    pc      = w.pc_in;
    i12     = {20'b0, w.immediate[11:0]};
    i16     = {16'b0, w.immediate[15:0]};
    jmp_off = {{11{w.immediate[20]}}, w.immediate[20:0]};
    br_off  = {{18{w.immediate[13]}}, w.immediate[13:0]};
    res     = '0;
    npc     = pc;
    cond    = 1'b0;
    case (w.kind)
      KAdd:  res = a + b;
      KSub:  res = a - b;
      KNot:  res = (b != 0) ? (~a + 32'd1) : ~a;
      KAnd:  res = a & b;
      KOr:   res = a | b;
      KXor:  res = a ^ b;
      KShl:  res = (b >= 32) ? '0 : (a << b[4:0]);
      KSar:  res = shift_arith(a, b);
      KShr:  res = (b >= 32) ? '0 : (a >> b[4:0]);
      KCmp:  res = compare3(a, b);
      KAddi: res = a + i12;
      KSubi: res = a - i12;
      KNoti: res = ~i12;
      KAndi: res = a & i12;
      KOri:  res = a | i12;
      KXori: res = a ^ i12;
      KShli: res = (i12 >= 32) ? '0 : (a << i12[4:0]);
      KSari: res = shift_arith(a, i12);
      KShri: res = (i12 >= 32) ? '0 : (a >> i12[4:0]);
      KCmpi: res = compare3(a, i16);
      KLi:   res = {{16{w.immediate[15]}}, w.immediate[15:0]};
      KLui:  res = {w.immediate[15:0], 16'b0};
      KLni:  res = i16;
      KJ:    npc = pc + jmp_off;
      KJal: begin
        res = pc + LinkStep;
        npc = jmp_off;
      end
      KJr: begin
        npc = (a == 0) ? pc + jmp_off : pc + a + {10'b0, w.immediate};
      end
      KJrl: begin
        res = pc + LinkStep;
        npc = (a == 0) ? jmp_off : pc + a + {10'b0, w.immediate};
      end
      KBeq, KBne, KBgt, KBlt: begin
        case (w.kind)
          KBeq:    cond = (a == b);
          KBne:    cond = (a != b);
          KBgt:    cond = ($signed(a) > $signed(b));
          default: cond = ($signed(a) < $signed(b));
        endcase
        npc = pc + (cond ? br_off : LinkStep);
      end
      default: ;
    endcase
    r.result  = res;
    r.next_pc = npc;
    r.taken   = cond;
    return r;
  endfunction

  task automatic add_instr(input logic [KindW-1:0] kind, input logic [XLEN-1:0] a,
                           input logic [XLEN-1:0] b, input logic [ImmW-1:0] imm,
                           input logic [XLEN-1:0] pc);
    ieu_req_t w;
    w.kind      = kind;
    w.operand_a = a;
    w.operand_b = b;
    w.immediate = imm;
    w.pc_in     = pc;
    pending_instrs.push_back(w);
  endtask

  // Operand with a bias toward boundary values
  function automatic logic [XLEN-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      4:       return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  // Random word, shaped per kind so shifts, compares and jumps hit their corners
  task automatic add_random_instr();
    logic [KindW-1:0] kind;
    logic [XLEN-1:0]  a, b;
    logic [ImmW-1:0]  imm;
    kind = KindW'($urandom_range(0, 31));
    a    = pick_word();
    b    = pick_word();
    imm  = ImmW'($urandom);
    case (kind)
      KShl, KSar, KShr: begin
        case ($urandom_range(0, 3))
          0, 1: b = $urandom_range(0, 31);
          2:    b = $urandom_range(32, 63);
          default: ;
        endcase
      end
      KShli, KSari, KShri: begin
        case ($urandom_range(0, 4))
          0, 1, 2: imm[11:0] = 12'($urandom_range(0, 31));
          3:       imm[11:0] = 12'($urandom_range(32, 4095));
          default: ;
        endcase
      end
      KCmp, KBeq, KBne, KBgt, KBlt: if ($urandom_range(0, 9) < 3) b = a;
      KCmpi: if ($urandom_range(0, 3) == 0) a = {$urandom_range(0, 1) ? 16'hFFFF : 16'h0,
                                                 imm[15:0]};
      KNot: if ($urandom_range(0, 1) == 0) b = '0;
      KJr, KJrl: if ($urandom_range(0, 9) < 4) a = '0;
      default: ;
    endcase
    add_instr(kind, a, b, imm, $urandom);
  endtask

  function automatic bit sender_idles();
    int unsigned pct;
    case (pacing_phase)
      1:       pct = 47;
      3:       pct = 25;
      default: pct = 0;
    endcase
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic bit receiver_stalls();
    int unsigned pct;
    case (pacing_phase)
      2:       pct = 47;
      3:       pct = 25;
      default: pct = 0;
    endcase
    return $urandom_range(0, 99) < pct;
  endfunction

  // Driver: record the accepted word, then present the next pending one
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    ieu_req_t cur, nxt;
    if (!rst_ni) begin
      valid_i <= 1'b0;
    end else begin
      if (valid_i && !stall_o) begin
        cur.kind      = kind_i;
        cur.operand_a = operand_a_i;
        cur.operand_b = operand_b_i;
        cur.immediate = immediate_i;
        cur.pc_in     = pc_in_i;
        expected_results.push_back(execute_instr(cur));
        kinds_seen[kind_i] = 1'b1;
      end
      if (!valid_i || !stall_o) begin
        if (pending_instrs.size() > 0 && !sender_idles()) begin
          nxt = pending_instrs.pop_front();
          kind_i      <= nxt.kind;
          operand_a_i <= nxt.operand_a;
          operand_b_i <= nxt.operand_b;
          immediate_i <= nxt.immediate;
          pc_in_i     <= nxt.pc_in;
          valid_i     <= 1'b1;
        end else begin
          valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result word with the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin : check_proc
    ieu_rsp_t want;
    if (!rst_ni) begin
      stall_i <= 1'b0;
    end else begin
      if (valid_o && !stall_i) begin
        if (expected_results.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result word result=%h next_pc=%h taken=%b",
                   $time, result_o, next_pc_o, taken_o);
        end else begin
          want = expected_results.pop_front();
          checked_count++;
          if (result_o !== want.result) begin
            err_count++;
            $display("%0t: result mismatch expected %h actual %h",
                     $time, want.result, result_o);
          end
          if (next_pc_o !== want.next_pc) begin
            err_count++;
            $display("%0t: next_pc mismatch expected %h actual %h",
                     $time, want.next_pc, next_pc_o);
          end
          if (taken_o !== want.taken) begin
            err_count++;
            $display("%0t: taken mismatch expected %b actual %b",
                     $time, want.taken, taken_o);
          end
        end
      end
      stall_i <= receiver_stalls();
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    // Directed words: field extremes, every kind and the corner cases
    add_instr(KAdd,  32'hFFFF_FFFF, 32'h1,         22'h0,      32'h0);
    add_instr(KSub,  32'h0,         32'h1,         22'h3FFFFF, 32'hFFFF_FFFF);
    add_instr(KNot,  32'h1234_5678, 32'h0,         22'h0,      32'h0);
    add_instr(KNot,  32'h8000_0000, 32'hFFFF_FFFF, 22'h0,      32'h0);
    add_instr(KAnd,  32'hFFFF_FFFF, 32'hA5A5_A5A5, 22'h0,      32'h0);
    add_instr(KOr,   32'h0,         32'h0,         22'h0,      32'h0);
    add_instr(KXor,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 22'h0,      32'h0);
    add_instr(KShl,  32'h1,         32'd31,        22'h0,      32'h0);
    add_instr(KShl,  32'hFFFF_FFFF, 32'd32,        22'h0,      32'h0);
    add_instr(KSar,  32'h8000_0000, 32'd40,        22'h0,      32'h0);
    add_instr(KSar,  32'h8000_0001, 32'd31,        22'h0,      32'h0);
    add_instr(KShr,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 22'h0,      32'h0);
    add_instr(KCmp,  32'd5,         32'd5,         22'h0,      32'h0);
    add_instr(KCmp,  32'h0,         32'hFFFF_FFFF, 22'h0,      32'h0);
    add_instr(KAddi, 32'hFFFF_FFFF, 32'h0,         22'h3FFFFF, 32'h0);
    add_instr(KSubi, 32'h0,         32'h0,         22'h000FFF, 32'h0);
    add_instr(KNoti, 32'h0,         32'h0,         22'h0,      32'h0);
    add_instr(KAndi, 32'hFFFF_FFFF, 32'h0,         22'h3FFFFF, 32'h0);
    add_instr(KOri,  32'h0,         32'h0,         22'h3FFFFF, 32'h0);
    add_instr(KXori, 32'hFFFF_FFFF, 32'h0,         22'h3FFFFF, 32'h0);
    add_instr(KShli, 32'h1,         32'h0,         22'h3FF020, 32'h0);
    add_instr(KSari, 32'h8000_0000, 32'h0,         22'h000FFF, 32'h0);
    add_instr(KShri, 32'hFFFF_FFFF, 32'h0,         22'h00001F, 32'h0);
    add_instr(KCmpi, 32'h0000_FFFF, 32'h0,         22'h3FFFFF, 32'h0);
    add_instr(KLi,   32'h0,         32'h0,         22'h008000, 32'h0);
    add_instr(KLui,  32'h0,         32'h0,         22'h3FFFFF, 32'h0);
    add_instr(KLni,  32'h0,         32'h0,         22'h00FFFF, 32'h0);
    add_instr(KJ,    32'h0,         32'h0,         22'h100000, 32'h0);
    add_instr(KJal,  32'h0,         32'h0,         22'h0FFFFF, 32'hFFFF_FFFC);
    add_instr(KJr,   32'h0,         32'h0,         22'h1FFFFF, 32'h0000_1000);
    add_instr(KJr,   32'hFFFF_FFFF, 32'h0,         22'h3FFFFF, 32'h0000_1000);
    add_instr(KJrl,  32'h0,         32'h0,         22'h100000, 32'h0000_2000);
    add_instr(KJrl,  32'h0000_0010, 32'h0,         22'h000004, 32'h0000_2000);
    add_instr(KBeq,  32'h7FFF_FFFF, 32'h7FFF_FFFF, 22'h002000, 32'h0000_0100);
    add_instr(KBne,  32'h7FFF_FFFF, 32'h7FFF_FFFF, 22'h001FFF, 32'h0000_0100);
    add_instr(KBgt,  32'h1,         32'hFFFF_FFFF, 22'h000040, 32'h0000_0100);
    add_instr(KBlt,  32'h8000_0000, 32'h7FFF_FFFF, 22'h3FFFFC, 32'h0000_0100);
    add_instr(KindReserved, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 22'h3FFFFF, 32'h1234_5678);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // One block of random words per pacing mode, drained before the next
    for (int p = 0; p < 4; p++) begin
      pacing_phase = p;
      for (int n = 0; n < RandPerPhase; n++) add_random_instr();
      while (pending_instrs.size() != 0 || expected_results.size() != 0 || valid_i)
        @(negedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);

    $display("Checked %0d result words covering %0d of 32 kind codes,", checked_count,
             $countones(kinds_seen));
    $display("under free-running, sender-gap, receiver-stall and mixed pacing.");
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", err_count);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
